// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the noise gate.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/ang_pkg.sv =====
// ----------------------------------------------------------------------------
// Noise gate package
// Widths, register indexes, reset values and shared types of the noise gate.
// ----------------------------------------------------------------------------
`default_nettype none

package ang_pkg;

   localparam int SAMPLE_WIDTH       = 16;
   localparam int HOLD_COUNT_WIDTH   = 25;
   localparam int GAIN_WIDTH         = 16;
   localparam int GAIN_FRAC          = 15;
   localparam int THRESH_WIDTH       = 16;
   localparam int STEP_WIDTH         = 16;
   localparam int HOLD_SAMPLES_WIDTH = 24;
   localparam int CSR_DATA_WIDTH     = 24;
   localparam int CSR_INDEX_WIDTH    = 3;

   // Widths used for the magnitude and hold comparisons and for the gain product.
   localparam int CMP_WIDTH      = (SAMPLE_WIDTH > THRESH_WIDTH) ? SAMPLE_WIDTH : THRESH_WIDTH;
   localparam int HOLD_CMP_WIDTH = (HOLD_COUNT_WIDTH > HOLD_SAMPLES_WIDTH) ?
                                   HOLD_COUNT_WIDTH : HOLD_SAMPLES_WIDTH;
   localparam int PROD_WIDTH     = SAMPLE_WIDTH + GAIN_WIDTH + 1;

   localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(1 << GAIN_FRAC);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPEN_THRESHOLD  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOSE_THRESHOLD = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTACK_STEP     = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_STEP    = CSR_INDEX_WIDTH'(3);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_SAMPLES    = CSR_INDEX_WIDTH'(4);

   typedef enum logic [1:0] {
      PH_CLOSED  = 2'd0,
      PH_OPEN    = 2'd1,
      PH_HOLD    = 2'd2,
      PH_RELEASE = 2'd3
   } gate_state_type;

   typedef struct packed {
      logic [THRESH_WIDTH-1:0]       open_threshold;
      logic [THRESH_WIDTH-1:0]       close_threshold;
      logic [STEP_WIDTH-1:0]         attack_step;
      logic [STEP_WIDTH-1:0]         release_step;
      logic [HOLD_SAMPLES_WIDTH-1:0] hold_samples;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      open_threshold:  THRESH_WIDTH'(1),
      close_threshold: THRESH_WIDTH'(1),
      attack_step:     STEP_WIDTH'(68),
      release_step:    STEP_WIDTH'(68),
      hold_samples:    HOLD_SAMPLES_WIDTH'(9600)
   };

   // Gate outcome of one sample, handed to the scaling stage.
   typedef struct packed {
      gate_state_type        phase;
      logic [GAIN_WIDTH-1:0] gain;
   } gate_out_type;

endpackage

`default_nettype wire

// ===== rtl/audio_noise_gate.sv =====
// Pipeline: a sample moves through the stage 0, stage 1 and output registers;
// the gate state update and the gain multiply each take one pipeline stage.
// Throughput: one sample per cycle, back to back, while rsp_stall is low.
// Reset: synchronous; the gate closes, the gain and hold count clear, the
// pipeline empties and the control registers take their default values.
// ----------------------------------------------------------------------------
// Audio noise gate
// Attack, hold and release gate on a signed sample stream with a Q1.15 gain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module audio_noise_gate
   import ang_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_sample_out,
   output logic [1:0]                          rsp_gate_phase,
   input  wire logic                           csr_wen,
   input  wire logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]      csr_wdata
);

   cfg_type      cfg;
   gate_out_type gate_next;

   logic                           s0_valid_ff;
   logic                           s0_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] s0_sample_ff;
   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_ff;
   gate_out_type                   s1_gate_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;

   logic req_take;
   logic rsp_load;
   logic s1_free;
   logic s0_move;
   logic s0_free;

   // Each stage moves on when the stage after it is empty or emptying.
   assign rsp_load = !rsp_valid_ff || !rsp_stall;
   assign s1_free  = !s1_valid_ff || rsp_load;
   assign s0_move  = s0_valid_ff && s1_free;
   assign s0_free  = !s0_valid_ff || s1_free;
   assign req_take = req_valid && s0_free;

   assign s0_valid_in  = req_take || (s0_valid_ff && !s1_free);
   assign s1_valid_in  = s0_move || (s1_valid_ff && !rsp_load);
   assign rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_sample_ff <= req_sample_in;
      end
      if (s0_move) begin
         s1_sample_ff <= s0_sample_ff;
         s1_gate_ff   <= gate_next;
      end
   end

   ang_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ang_gate u_gate (
      .clock    (clock),
      .reset    (reset),
      .step     (s0_move),
      .sample   (s0_sample_ff),
      .cfg      (cfg),
      .gate_out (gate_next)
   );

   ang_scale u_scale (
      .clock      (clock),
      .load       (rsp_load && s1_valid_ff),
      .sample     (s1_sample_ff),
      .gate_out   (s1_gate_ff),
      .sample_out (rsp_sample_out),
      .gate_phase (rsp_gate_phase)
   );

   assign req_stall = !s0_free;
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_CLK(a_stall_full, req_stall |-> s0_valid_ff, "input stalled with an empty stage")

endmodule

`default_nettype wire

// ===== rtl/ang_csr.sv =====
// ----------------------------------------------------------------------------
// Noise gate control registers
// Holds the thresholds, ramp steps and hold length written over the CSR port.
// ----------------------------------------------------------------------------
`default_nettype none

module ang_csr
   import ang_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wen,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_OPEN_THRESHOLD:  cfg_in.open_threshold  = csr_wdata[THRESH_WIDTH-1:0];
            CSR_CLOSE_THRESHOLD: cfg_in.close_threshold = csr_wdata[THRESH_WIDTH-1:0];
            CSR_ATTACK_STEP:     cfg_in.attack_step     = csr_wdata[STEP_WIDTH-1:0];
            CSR_RELEASE_STEP:    cfg_in.release_step    = csr_wdata[STEP_WIDTH-1:0];
            CSR_HOLD_SAMPLES:    cfg_in.hold_samples    = csr_wdata[HOLD_SAMPLES_WIDTH-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/ang_gate.sv =====
// ----------------------------------------------------------------------------
// Noise gate state machine
// Tracks the gate phase, the Q1.15 gain and the hold counter, one sample a step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ang_gate
   import ang_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
   input  wire cfg_type                        cfg,
   output gate_out_type                        gate_out
);

   gate_state_type              state_ff;
   gate_state_type              state_in;
   logic [GAIN_WIDTH-1:0]       gain_ff;
   logic [GAIN_WIDTH-1:0]       gain_in;
   logic [HOLD_COUNT_WIDTH-1:0] hold_ff;
   logic [HOLD_COUNT_WIDTH-1:0] hold_in;

   logic [SAMPLE_WIDTH-1:0] mag;
   logic                    above_open;
   logic                    below_close;
   logic                    hold_done;
   logic [GAIN_WIDTH:0]     attack_sum;

   // The full-scale negative sample maps to 2^(SAMPLE_WIDTH-1), which fits unsigned.
   assign mag         = sample[SAMPLE_WIDTH-1] ? (~sample + 1'b1) : sample;
   assign above_open  = CMP_WIDTH'(mag) > CMP_WIDTH'(cfg.open_threshold);
   assign below_close = CMP_WIDTH'(mag) < CMP_WIDTH'(cfg.close_threshold);
   assign hold_done   = HOLD_CMP_WIDTH'(hold_ff) > HOLD_CMP_WIDTH'(cfg.hold_samples);
   assign attack_sum  = {1'b0, gain_ff} + (GAIN_WIDTH + 1)'(cfg.attack_step);

   always_comb begin
      state_in = state_ff;
      gain_in  = gain_ff;
      hold_in  = hold_ff;
      if (step) begin
         case (state_ff)
            PH_CLOSED: begin
               if (above_open) begin
                  state_in = PH_OPEN;
               end
            end
            PH_OPEN: begin
               if (below_close) begin
                  hold_in  = '0;
                  state_in = PH_HOLD;
               end else if (gain_ff < GAIN_ONE) begin
                  gain_in = (attack_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE
                                                            : attack_sum[GAIN_WIDTH-1:0];
               end
            end
            PH_HOLD: begin
               if (above_open) begin
                  state_in = PH_OPEN;
               end else begin
                  // The counter sticks at all ones; the test uses the value before the step.
                  if (hold_ff != '1) begin
                     hold_in = hold_ff + 1'b1;
                  end
                  if (hold_done) begin
                     state_in = PH_RELEASE;
                  end
               end
            end
            PH_RELEASE: begin
               if (gain_ff != '0) begin
                  gain_in = (gain_ff > cfg.release_step) ? (gain_ff - cfg.release_step) : '0;
               end else begin
                  state_in = PH_CLOSED;
               end
            end
            default: begin
               state_in = PH_CLOSED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_CLOSED;
         gain_ff  <= '0;
         hold_ff  <= '0;
      end else begin
         state_ff <= state_in;
         gain_ff  <= gain_in;
         hold_ff  <= hold_in;
      end
   end

   assign gate_out.phase = state_in;
   assign gate_out.gain  = gain_in;

   `ASSERT_CLK(a_gain_limit, gain_ff <= GAIN_ONE, "gain above unity")
   `ASSERT_CLK(a_closed_mute, (state_ff == PH_CLOSED) |-> (gain_ff == '0),
               "closed gate with nonzero gain")
   `ASSERT_CLK(a_idle_hold, !step |=> ($stable(gain_ff) && $stable(state_ff)),
               "gate state changed without a sample")

endmodule

`default_nettype wire

// ===== rtl/ang_scale.sv =====
// ----------------------------------------------------------------------------
// Noise gate output scaling
// Multiplies the sample by the Q1.15 gain and registers the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ang_scale
   import ang_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
   input  wire gate_out_type                   gate_out,
   output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
   output logic [1:0]                          gate_phase
);

   logic signed [PROD_WIDTH-1:0]   prod;
   logic signed [SAMPLE_WIDTH-1:0] sample_out_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_out_in;
   logic [1:0]                     gate_phase_ff;

   // Taking bits above the fraction of the two's complement product is a floor division.
   assign prod          = PROD_WIDTH'(sample) * PROD_WIDTH'($signed({1'b0, gate_out.gain}));
   assign sample_out_in = prod[GAIN_FRAC+SAMPLE_WIDTH-1:GAIN_FRAC];

   always_ff @(posedge clock) begin
      if (load) begin
         sample_out_ff <= sample_out_in;
         gate_phase_ff <= gate_out.phase;
      end
   end

   assign sample_out = sample_out_ff;
   assign gate_phase = gate_phase_ff;

endmodule

`default_nettype wire

// ===== tb/sv/ang_gate_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Noise gate checker
// Watches the sample, result and register ports of the noise gate. It keeps
// its own gate state and register copy, computes the gated sample and phase
// for every accepted sample, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module ang_gate_checker
   import ang_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_sample_in,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]   rsp_sample_out,
   input  logic [1:0]                       rsp_gate_phase,
   input  logic                             csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]        csr_wdata,
   output int                               fail_count,
   output int                               pending
);

   localparam int UNITY_GAIN = 1 << GAIN_FRAC;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample_out;
      gate_state_type          gate_phase;
   } gated_sample_type;

   cfg_type                       regs = CFG_RESET;
   gate_state_type                phase_q = PH_CLOSED;
   int                            gain_q = 0;
   logic [HOLD_COUNT_WIDTH-1:0]   hold_q = '0;
   gated_sample_type              gated_samples[$];
   int                            fails = 0;

   // Advances the gate by one sample and returns the scaled sample and phase.
   function automatic gated_sample_type apply_gate(input logic signed [SAMPLE_WIDTH-1:0] s);
      longint                      level;
      longint                      mag;
      longint                      raised;
      longint                      product;
      logic [HOLD_COUNT_WIDTH-1:0] held;
      gated_sample_type            r;
      level = s;
      mag = (level < 0) ? -level : level;
      case (phase_q)
         PH_CLOSED: begin
            if (mag > longint'(regs.open_threshold)) phase_q = PH_OPEN;
         end
         PH_OPEN: begin
            if (mag < longint'(regs.close_threshold)) begin
               hold_q = '0;
               phase_q = PH_HOLD;
            end else if (gain_q < UNITY_GAIN) begin
               raised = gain_q + longint'(regs.attack_step);
               gain_q = (raised > UNITY_GAIN) ? UNITY_GAIN : int'(raised);
            end
         end
         PH_HOLD: begin
            if (mag > longint'(regs.open_threshold)) begin
               phase_q = PH_OPEN;
            end else begin
               held = hold_q;
               if (hold_q != '1) hold_q = hold_q + 1'b1;
               if (held > HOLD_COUNT_WIDTH'(regs.hold_samples)) phase_q = PH_RELEASE;
            end
         end
         PH_RELEASE: begin
            if (gain_q > 0) begin
               gain_q = (gain_q > int'(regs.release_step)) ?
                        gain_q - int'(regs.release_step) : 0;
            end else begin
               phase_q = PH_CLOSED;
            end
         end
         default: ;
      endcase
      // An arithmetic shift of the signed product rounds toward minus infinity.
      product = level * longint'(gain_q);
      r.sample_out = SAMPLE_WIDTH'(product >>> GAIN_FRAC);
      r.gate_phase = phase_q;
      return r;
   endfunction

   always @(posedge clock) begin
      gated_sample_type want;
      if (reset) begin
         regs = CFG_RESET;
         phase_q = PH_CLOSED;
         gain_q = 0;
         hold_q = '0;
         gated_samples.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_OPEN_THRESHOLD:  regs.open_threshold  = csr_wdata[THRESH_WIDTH-1:0];
               CSR_CLOSE_THRESHOLD: regs.close_threshold = csr_wdata[THRESH_WIDTH-1:0];
               CSR_ATTACK_STEP:     regs.attack_step     = csr_wdata[STEP_WIDTH-1:0];
               CSR_RELEASE_STEP:    regs.release_step    = csr_wdata[STEP_WIDTH-1:0];
               CSR_HOLD_SAMPLES:    regs.hold_samples    = csr_wdata[HOLD_SAMPLES_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) gated_samples.push_back(apply_gate(req_sample_in));
         if (rsp_valid && !rsp_stall) begin
            if (gated_samples.size() == 0) begin
               $error("sample_out: no transaction expected, actual %0d", rsp_sample_out);
               fails++;
            end else begin
               want = gated_samples.pop_front();
               if (rsp_sample_out !== want.sample_out) begin
                  $error("sample_out: expected %0d, actual %0d",
                         $signed(want.sample_out), rsp_sample_out);
                  fails++;
               end
               if (rsp_gate_phase !== want.gate_phase) begin
                  $error("gate_phase: expected %0d, actual %0d",
                         want.gate_phase, rsp_gate_phase);
                  fails++;
               end
            end
         end
      end
      fail_count <= fails;
      pending <= gated_samples.size();
   end

endmodule

// ===== tb/sv/tb_audio_noise_gate.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Noise gate testbench
// Drives sample streams through the noise gate under a series of register
// settings, from a directed walk through every gate phase to random bursts of
// loud and quiet samples, with random gaps on the sample channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
module tb_audio_noise_gate;
   import ang_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 100;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_UNUSED = CSR_HOLD_SAMPLES + 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAST_UNUSED  = '1;

   localparam int BURST_LOUD  = 0;
   localparam int BURST_QUIET = 1;
   localparam int BURST_NOISE = 2;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_in = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out;
   logic [1:0]                     rsp_gate_phase;
   logic                           csr_wen = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]      csr_wdata = '0;

   int fail_count;
   int pending;
   int quiet_cycles = 0;
   bit steady = 1'b0;

   logic signed [SAMPLE_WIDTH-1:0] gate_walk [22] = '{
      '0, '0, '0, '0, '0, '0, '0,
      16'sd100, -16'sd101, 16'sd32767, 16'sh8000, 16'sd49, 16'sd101, 16'sd50,
      '0, '0, '0, '0, '0, 16'sh8000, '0, '0
   };

   audio_noise_gate u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_gate_phase (rsp_gate_phase),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   ang_gate_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_gate_phase (rsp_gate_phase),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 22);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Returns at the edge where the transaction was accepted, with valid still high.
   task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] value);
      if (!steady) begin
         while ($urandom_range(99) < 22) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_sample_in <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Unused upper bits of the narrow registers carry junk, and a write to an
   // unmapped index follows, to show that both are ignored.
   task automatic program_gate(input cfg_type c);
      write_csr(CSR_OPEN_THRESHOLD,  {8'($urandom), c.open_threshold});
      write_csr(CSR_CLOSE_THRESHOLD, {8'($urandom), c.close_threshold});
      write_csr(CSR_ATTACK_STEP,     {8'($urandom), c.attack_step});
      write_csr(CSR_RELEASE_STEP,    {8'($urandom), c.release_step});
      write_csr(CSR_HOLD_SAMPLES,    c.hold_samples);
      write_csr(CSR_INDEX_WIDTH'($urandom_range(CSR_LAST_UNUSED, CSR_FIRST_UNUSED)),
                CSR_DATA_WIDTH'($urandom));
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cfg_type pick_config(input int phase_no);
      cfg_type c;
      c.open_threshold  = 16'($urandom_range(32768));
      c.close_threshold = 16'($urandom_range(int'(c.open_threshold)));
      c.attack_step     = $urandom_range(1) ? 16'($urandom_range(32768, 1))
                                            : 16'($urandom_range(600, 1));
      c.release_step    = $urandom_range(1) ? 16'($urandom_range(32768, 1))
                                            : 16'($urandom_range(600, 1));
      c.hold_samples    = 24'($urandom_range(20));
      case (phase_no)
         0: begin
            c.open_threshold  = '0;
            c.close_threshold = '0;
            c.attack_step     = STEP_WIDTH'(32768);
            c.release_step    = STEP_WIDTH'(32768);
            c.hold_samples    = '0;
         end
         1: begin
            // Nothing can exceed these thresholds, so the gate only winds down.
            c.open_threshold  = '1;
            c.close_threshold = '1;
            c.attack_step     = '1;
            c.release_step    = '1;
            c.hold_samples    = 24'd1;
         end
         3: begin
            c.attack_step  = 16'd1;
            c.release_step = 16'd1;
            c.hold_samples = '1;
         end
         6: begin
            // Zero steps freeze the gain; a releasing gate then stays there.
            c.attack_step  = '0;
            c.release_step = '0;
            c.hold_samples = 24'($urandom_range(5));
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] shape_sample(input int kind,
                                                                  input cfg_type c);
      int mag;
      logic signed [SAMPLE_WIDTH-1:0] s;
      if (kind == BURST_LOUD && int'(c.open_threshold) < 32768) begin
         mag = $urandom_range(32768, int'(c.open_threshold) + 1);
      end else if (kind == BURST_QUIET) begin
         if (c.close_threshold == '0) begin
            mag = 0;
         end else if (int'(c.close_threshold) > 32768) begin
            mag = $urandom_range(32768);
         end else begin
            mag = $urandom_range(int'(c.close_threshold) - 1);
         end
      end else begin
         return SAMPLE_WIDTH'($urandom);
      end
      if (mag == 32768) return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      s = SAMPLE_WIDTH'(mag);
      return $urandom_range(1) ? -s : s;
   endfunction

   // Loud and quiet bursts walk the gate through its phases; noise bursts
   // break the pattern.
   task automatic run_bursts(input cfg_type c, input int count);
      int sent;
      int pick;
      int kind;
      int span;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(9);
         if (pick < 4) begin
            kind = BURST_LOUD;
            span = $urandom_range(12, 1);
         end else if (pick < 8) begin
            kind = BURST_QUIET;
            span = $urandom_range(40, 1);
         end else begin
            kind = BURST_NOISE;
            span = $urandom_range(6, 1);
         end
         repeat (span) begin
            push_sample(shape_sample(kind, c));
            sent++;
         end
      end
   endtask

   initial begin
      cfg_type c;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default registers: a magnitude of two opens the gate.
      push_sample(16'sd1);
      push_sample(-16'sd2);
      push_sample(16'sd2);
      settle();

      c.open_threshold  = 16'd100;
      c.close_threshold = 16'd50;
      c.attack_step     = 16'd16384;
      c.release_step    = 16'd16384;
      c.hold_samples    = 24'd2;
      program_gate(c);
      foreach (gate_walk[i]) push_sample(gate_walk[i]);
      settle();

      for (int p = 0; p < 8; p++) begin
         c = pick_config(p);
         program_gate(c);
         steady <= (p == 4);
         run_bursts(c, PHASE_ITEMS);
         settle();
      end

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ang_pkg.sv
rtl/ang_csr.sv
rtl/ang_gate.sv
rtl/ang_scale.sv
rtl/audio_noise_gate.sv
tb/sv/ang_gate_checker.sv
tb/sv/tb_audio_noise_gate.sv
